@@ rtl/core/quaternion_vector_rotate_defines.svh @@
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_defines.svh
// Assertion macros used by the checker file of the rotation block.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define QVR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block clock and reset.
`define QVR_ASSERT(lbl, prop, msg) \
  `QVR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/core/qvr_pkg.sv @@
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, defaults and stage payload types of the quaternion rotation block.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QUAT_W   = 16;            // quaternion component field
  localparam int ACC_IN_W = 16;            // body acceleration field
  localparam int OUT_W    = 17;            // world acceleration field
  localparam int A_W      = ACC_IN_W + 1;  // acceleration after extension
  localparam int PROD_W   = 2 * QUAT_W;    // quaternion pair product
  localparam int TERM_W   = PROD_W + 1;    // off-unit part of a matrix element
  localparam int PART_W   = A_W + TERM_W;  // acceleration times matrix term
  localparam int DOT_W    = 64;            // dot product, wraps mod 2^64

  localparam int STAGES   = 5;             // register stages, input to output

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int ACC_WIDTH_DEF      = 16;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Matrix element (i,j) is delta(i,j) * 1.0 + 2 * m[i][j].
  typedef struct {
    logic signed [TERM_W-1:0] m [3][3];
    logic signed [A_W-1:0]    a [3];
  } qvr_term_t;

  typedef logic signed [DOT_W-1:0] qvr_dot_t;

endpackage

@@ rtl/core/qvr_if.sv @@
// ----------------------------------------------------------------------------
// qvr_in_if / qvr_out_if
// Valid/ready channels carrying quaternion and acceleration items.
// ----------------------------------------------------------------------------
interface qvr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qvr_pkg::QUAT_W-1:0]     quat_w;
  logic signed [qvr_pkg::QUAT_W-1:0]     quat_x;
  logic signed [qvr_pkg::QUAT_W-1:0]     quat_y;
  logic signed [qvr_pkg::QUAT_W-1:0]     quat_z;
  logic signed [qvr_pkg::ACC_IN_W-1:0]   body_acc_x;
  logic signed [qvr_pkg::ACC_IN_W-1:0]   body_acc_y;
  logic signed [qvr_pkg::ACC_IN_W-1:0]   body_acc_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, body_acc_x, body_acc_y, body_acc_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, body_acc_x, body_acc_y, body_acc_z,
    output ready
  );
endinterface

interface qvr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qvr_pkg::OUT_W-1:0]   world_acc_x;
  logic signed [qvr_pkg::OUT_W-1:0]   world_acc_y;
  logic signed [qvr_pkg::OUT_W-1:0]   world_acc_z;

  modport source (output valid, world_acc_x, world_acc_y, world_acc_z, input ready);
  modport sink   (input valid, world_acc_x, world_acc_y, world_acc_z, output ready);
endinterface

@@ rtl/core/qvr_mat_terms.sv @@
// ----------------------------------------------------------------------------
// qvr_mat_terms
// Stages 1-2: quaternion pair products, then rotation matrix terms.
// ----------------------------------------------------------------------------
module qvr_mat_terms #(
  parameter int ACC_WIDTH = qvr_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_w_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_x_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_y_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_z_i,
  input  logic signed [qvr_pkg::ACC_IN_W-1:0]  body_acc_x_i,
  input  logic signed [qvr_pkg::ACC_IN_W-1:0]  body_acc_y_i,
  input  logic signed [qvr_pkg::ACC_IN_W-1:0]  body_acc_z_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output qvr_pkg::qvr_term_t                   term_o
);

  localparam int A_W    = qvr_pkg::A_W;
  localparam int PROD_W = qvr_pkg::PROD_W;
  localparam int TERM_W = qvr_pkg::TERM_W;
  localparam int ACC_SH = (ACC_WIDTH >= qvr_pkg::ACC_IN_W) ? 0
                                                          : qvr_pkg::ACC_IN_W - ACC_WIDTH;

  // Low ACC_WIDTH bits as two's complement; a wider setting sees the field unsigned.
  function automatic logic signed [A_W-1:0] acc_ext(
    input logic [qvr_pkg::ACC_IN_W-1:0] raw
  );
    logic signed [A_W-1:0] t;
    t = A_W'({raw, 1'b0} << ACC_SH);
    if (ACC_WIDTH > qvr_pkg::ACC_IN_W) begin
      return {1'b0, raw};
    end
    return t >>> (ACC_SH + 1);
  endfunction

  typedef struct packed {
    logic signed [PROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [A_W-1:0]    ax, ay, az;
  } prod_t;

  logic               v1_q, v2_q;
  logic               en1, en2;
  prod_t              prod_d, prod_q;
  qvr_pkg::qvr_term_t term_d, term_q;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign term_o  = term_q;

  always_comb begin
    prod_d.xx = quat_x_i * quat_x_i;
    prod_d.yy = quat_y_i * quat_y_i;
    prod_d.zz = quat_z_i * quat_z_i;
    prod_d.xy = quat_x_i * quat_y_i;
    prod_d.xz = quat_x_i * quat_z_i;
    prod_d.yz = quat_y_i * quat_z_i;
    prod_d.wx = quat_w_i * quat_x_i;
    prod_d.wy = quat_w_i * quat_y_i;
    prod_d.wz = quat_w_i * quat_z_i;
    prod_d.ax = acc_ext(body_acc_x_i);
    prod_d.ay = acc_ext(body_acc_y_i);
    prod_d.az = acc_ext(body_acc_z_i);
  end

  always_comb begin
    term_d.m[0][0] = -(TERM_W'(prod_q.yy) + TERM_W'(prod_q.zz));
    term_d.m[0][1] = TERM_W'(prod_q.xy) - TERM_W'(prod_q.wz);
    term_d.m[0][2] = TERM_W'(prod_q.xz) + TERM_W'(prod_q.wy);
    term_d.m[1][0] = TERM_W'(prod_q.xy) + TERM_W'(prod_q.wz);
    term_d.m[1][1] = -(TERM_W'(prod_q.xx) + TERM_W'(prod_q.zz));
    term_d.m[1][2] = TERM_W'(prod_q.yz) - TERM_W'(prod_q.wx);
    term_d.m[2][0] = TERM_W'(prod_q.xz) - TERM_W'(prod_q.wy);
    term_d.m[2][1] = TERM_W'(prod_q.yz) + TERM_W'(prod_q.wx);
    term_d.m[2][2] = -(TERM_W'(prod_q.xx) + TERM_W'(prod_q.yy));
    term_d.a[0]    = prod_q.ax;
    term_d.a[1]    = prod_q.ay;
    term_d.a[2]    = prod_q.az;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
    end
    if (en2) begin
      term_q <= term_d;
    end
  end

endmodule

@@ rtl/core/qvr_mat_vec.sv @@
// ----------------------------------------------------------------------------
// qvr_mat_vec
// Stages 3-4: matrix term products, then the three dot products.
// ----------------------------------------------------------------------------
module qvr_mat_vec #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  qvr_pkg::qvr_term_t  term_i,
  output logic                valid_o,
  input  logic                ready_i,
  output qvr_pkg::qvr_dot_t   dot_o [3]
);

  localparam int A_W    = qvr_pkg::A_W;
  localparam int PART_W = qvr_pkg::PART_W;
  localparam int DOT_W  = qvr_pkg::DOT_W;
  localparam int ONE_SH = 2 * QUAT_FRAC_BITS;

  logic                    v3_q, v4_q;
  logic                    en3, en4;
  logic signed [PART_W-1:0] part_d [3][3];
  logic signed [PART_W-1:0] part_q [3][3];
  logic signed [A_W-1:0]    a_q [3];
  qvr_pkg::qvr_dot_t        dot_d [3];
  qvr_pkg::qvr_dot_t        dot_q [3];

  assign en4     = ~v4_q | ready_i;
  assign en3     = ~v3_q | en4;
  assign ready_o = en3;
  assign valid_o = v4_q;
  assign dot_o   = dot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        part_d[i][j] = PART_W'(term_i.a[j]) * PART_W'(term_i.m[i][j]);
      end
    end
  end

  // Unit diagonal enters as a shifted copy of the own component; sum wraps mod 2^64.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dot_d[i] = (DOT_W'(a_q[i]) <<< ONE_SH)
               + ((DOT_W'(part_q[i][0]) + DOT_W'(part_q[i][1]) + DOT_W'(part_q[i][2])) <<< 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      part_q <= part_d;
      a_q    <= term_i.a;
    end
    if (en4) begin
      dot_q <= dot_d;
    end
  end

endmodule

@@ rtl/core/qvr_round_sat.sv @@
// ----------------------------------------------------------------------------
// qvr_round_sat
// Stage 5: round to nearest (ties up), saturate, output register.
// ----------------------------------------------------------------------------
module qvr_round_sat #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  qvr_pkg::qvr_dot_t                 dot_i [3],
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [qvr_pkg::OUT_W-1:0]  world_acc_x_o,
  output logic signed [qvr_pkg::OUT_W-1:0]  world_acc_y_o,
  output logic signed [qvr_pkg::OUT_W-1:0]  world_acc_z_o
);

  localparam int OUT_W  = qvr_pkg::OUT_W;
  localparam int DOT_W  = qvr_pkg::DOT_W;
  localparam int FRAC   = 2 * QUAT_FRAC_BITS;
  localparam qvr_pkg::qvr_dot_t HALF = qvr_pkg::qvr_dot_t'(1) <<< (FRAC - 1);

  logic                    v5_q;
  logic                    en5;
  qvr_pkg::qvr_dot_t       rnd [3];
  qvr_pkg::qvr_dot_t       shr [3];
  logic signed [OUT_W-1:0] res_d [3];
  logic signed [OUT_W-1:0] res_q [3];

  assign en5           = ~v5_q | ready_i;
  assign ready_o       = en5;
  assign valid_o       = v5_q;
  assign world_acc_x_o = res_q[0];
  assign world_acc_y_o = res_q[1];
  assign world_acc_z_o = res_q[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = dot_i[i] + HALF;
      shr[i] = rnd[i] >>> FRAC;
      // In range when all bits above the output sign agree with it.
      if ((&shr[i][DOT_W-1:OUT_W-1]) || !(|shr[i][DOT_W-1:OUT_W-1])) begin
        res_d[i] = shr[i][OUT_W-1:0];
      end else if (shr[i][DOT_W-1]) begin
        res_d[i] = qvr_pkg::OUT_MIN;
      end else begin
        res_d[i] = qvr_pkg::OUT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      res_q <= res_d;
    end
  end

endmodule

@@ rtl/core/quaternion_vector_rotate.sv @@
// Throughput: one item per cycle while the output is not stalled; five
// register stages (pair products, matrix terms, term products, dot sums,
// round/saturate), each with its own valid bit.
// A stage advances when it is empty or the next one advances, so bubbles fill.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a body-frame acceleration vector into the world frame with a Q1.F
// orientation quaternion; results rounded to nearest and saturated to 17 bits.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
  parameter int ACC_WIDTH      = qvr_pkg::ACC_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qvr_in_if.sink     in_i,
  qvr_out_if.source  out_o
);

  logic               t_valid, t_ready;
  logic               d_valid, d_ready;
  qvr_pkg::qvr_term_t term;
  qvr_pkg::qvr_dot_t  dot [3];

  qvr_mat_terms #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_terms (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .quat_w_i     (in_i.quat_w),
    .quat_x_i     (in_i.quat_x),
    .quat_y_i     (in_i.quat_y),
    .quat_z_i     (in_i.quat_z),
    .body_acc_x_i (in_i.body_acc_x),
    .body_acc_y_i (in_i.body_acc_y),
    .body_acc_z_i (in_i.body_acc_z),
    .valid_o      (t_valid),
    .ready_i      (t_ready),
    .term_o       (term)
  );

  qvr_mat_vec #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_mat_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t_valid),
    .ready_o (t_ready),
    .term_i  (term),
    .valid_o (d_valid),
    .ready_i (d_ready),
    .dot_o   (dot)
  );

  qvr_round_sat #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round_sat (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (d_valid),
    .ready_o       (d_ready),
    .dot_i         (dot),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .world_acc_x_o (out_o.world_acc_x),
    .world_acc_y_o (out_o.world_acc_y),
    .world_acc_z_o (out_o.world_acc_z)
  );

endmodule

@@ rtl/core/qvr_checker.sv @@
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks of the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_defines.svh"

module qvr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [qvr_pkg::OUT_W-1:0]  world_acc_x_i,
  input logic signed [qvr_pkg::OUT_W-1:0]  world_acc_y_i,
  input logic signed [qvr_pkg::OUT_W-1:0]  world_acc_z_i
);

  localparam int CNT_W = $clog2(qvr_pkg::STAGES + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Items accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `QVR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(world_acc_x_i) && $stable(world_acc_y_i) && $stable(world_acc_z_i), "stalled result changed")
  `QVR_ASSERT(a_no_invent, out_valid_i |-> cnt_q != '0, "result without an item in flight")
  `QVR_ASSERT(a_depth, cnt_q <= CNT_W'(qvr_pkg::STAGES), "more items in flight than stages")
  `QVR_ASSERT(a_ready_free, !out_valid_i || out_ready_i |-> in_ready_i, "input stalled with free output")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .world_acc_x_i (out_o.world_acc_x),
  .world_acc_y_i (out_o.world_acc_y),
  .world_acc_z_i (out_o.world_acc_z)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_vector_rotate. A short table of directed
// items (identity and half-turn quaternions, non-unit and saturating inputs,
// rounding ties) is followed by random items: unit, in-range and raw 16-bit
// quaternions with mixed acceleration values. Each result is compared with the
// typed value or a fixed-point rotation model; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW         = qvr_pkg::QUAT_W;
  localparam int AW         = qvr_pkg::ACC_IN_W;
  localparam int OW         = qvr_pkg::OUT_W;
  localparam int QF         = qvr_pkg::QUAT_FRAC_BITS_DEF;
  localparam int FRAC2      = 2 * QF;
  localparam int ONE_Q      = 1 << QF;
  localparam int RAND_ITEMS = 1230;
  localparam int IDLE_LIMIT = 1000;

  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  typedef struct {
    logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [AW-1:0] body_acc_x, body_acc_y, body_acc_z;
  } body_item_t;

  typedef struct {
    logic signed [OW-1:0] world_acc_x, world_acc_y, world_acc_z;
  } world_item_t;

  typedef struct {
    body_item_t  vec;
    bit          known;   // expected result typed in the table
    world_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  qvr_in_if  in_if ();
  qvr_out_if out_if ();

  quaternion_vector_rotate #(
    .QUAT_FRAC_BITS (QF),
    .ACC_WIDTH      (qvr_pkg::ACC_WIDTH_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  world_item_t world_expected [$];
  stim_row_t   stim_rows [$];
  int          err_count = 0;
  int          results_checked = 0;
  int          items_sent;
  int          burst_left;
  int          idle_cycles;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Round half up by dropping the 2F fraction bits, then clamp to 17 bits.
  function automatic logic signed [OW-1:0] round_saturate(input longint dot);
    longint r;
    r = (dot + (longint'(1) <<< (FRAC2 - 1))) >>> FRAC2;
    if (r > longint'(qvr_pkg::OUT_MAX))
      r = longint'(qvr_pkg::OUT_MAX);
    else if (r < longint'(qvr_pkg::OUT_MIN))
      r = longint'(qvr_pkg::OUT_MIN);
    return r[OW-1:0];
  endfunction

  function automatic world_item_t rotate_vector(input body_item_t b);
    longint      w, x, y, z, ax, ay, az, one;
    longint      m [3][3];
    world_item_t res;
    w   = b.quat_w;
    x   = b.quat_x;
    y   = b.quat_y;
    z   = b.quat_z;
    ax  = b.body_acc_x;
    ay  = b.body_acc_y;
    az  = b.body_acc_z;
    one = longint'(1) <<< FRAC2;
    m[0][0] = one - 2 * (y * y + z * z);
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = one - 2 * (x * x + z * z);
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = one - 2 * (x * x + y * y);
    res.world_acc_x = round_saturate(ax * m[0][0] + ay * m[0][1] + az * m[0][2]);
    res.world_acc_y = round_saturate(ax * m[1][0] + ay * m[1][1] + az * m[1][2]);
    res.world_acc_z = round_saturate(ax * m[2][0] + ay * m[2][1] + az * m[2][2]);
    return res;
  endfunction

  function automatic logic signed [AW-1:0] random_accel();
    case ($urandom_range(0, 9))
      6, 7: return AW'(int'($urandom_range(0, 4095)) - 2048);
      8: begin
        case ($urandom_range(0, 3))
          0: return ACC_MIN;
          1: return ACC_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      9: return AW'(int'($urandom_range(0, 2)) - 1);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic body_item_t random_vector();
    body_item_t v;
    real        c [4];
    real        n;
    int         q [4];
    case ($urandom_range(0, 3))
      0, 1: begin
        // unit quaternion from a random direction
        for (int k = 0; k < 4; k++)
          c[k] = real'(int'($urandom_range(0, 65535)) - 32768);
        n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        if (n < 1.0) begin
          q = '{ONE_Q, 0, 0, 0};
        end else begin
          for (int k = 0; k < 4; k++)
            q[k] = $rtoi(c[k] / n * real'(ONE_Q));
        end
      end
      2: begin
        for (int k = 0; k < 4; k++)
          q[k] = int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
      end
      default: begin
        for (int k = 0; k < 4; k++)
          q[k] = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    v.quat_w     = QW'(q[0]);
    v.quat_x     = QW'(q[1]);
    v.quat_y     = QW'(q[2]);
    v.quat_z     = QW'(q[3]);
    v.body_acc_x = random_accel();
    v.body_acc_y = random_accel();
    v.body_acc_z = random_accel();
    return v;
  endfunction

  task automatic add_row(input int w, x, y, z, ax, ay, az, input bit known,
                         input int ox = 0, oy = 0, oz = 0);
    stim_row_t r;
    r.vec.quat_w           = QW'(w);
    r.vec.quat_x           = QW'(x);
    r.vec.quat_y           = QW'(y);
    r.vec.quat_z           = QW'(z);
    r.vec.body_acc_x       = AW'(ax);
    r.vec.body_acc_y       = AW'(ay);
    r.vec.body_acc_z       = AW'(az);
    r.known                = known;
    r.want.world_acc_x     = OW'(ox);
    r.want.world_acc_y     = OW'(oy);
    r.want.world_acc_z     = OW'(oz);
    stim_rows.push_back(r);
  endtask

  // Sender works in bursts; between bursts valid may drop for a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(13, 30);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic drive_item(input body_item_t v);
    in_if.valid      <= 1'b1;
    in_if.quat_w     <= v.quat_w;
    in_if.quat_x     <= v.quat_x;
    in_if.quat_y     <= v.quat_y;
    in_if.quat_z     <= v.quat_z;
    in_if.body_acc_x <= v.body_acc_x;
    in_if.body_acc_y <= v.body_acc_y;
    in_if.body_acc_z <= v.body_acc_z;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_sent++;
  endtask

  initial begin : stimulus
    body_item_t v;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.quat_w     <= '0;
    in_if.quat_x     <= '0;
    in_if.quat_y     <= '0;
    in_if.quat_z     <= '0;
    in_if.body_acc_x <= '0;
    in_if.body_acc_y <= '0;
    in_if.body_acc_z <= '0;
    items_sent      = 0;
    burst_left      = 0;

    // identity and zero quaternions pass the vector through
    add_row(ONE_Q, 0, 0, 0, 1000, -2000, 3000, 1, 1000, -2000, 3000);
    add_row(ONE_Q, 0, 0, 0, 32767, 32767, 32767, 1, 32767, 32767, 32767);
    add_row(ONE_Q, 0, 0, 0, -32768, -32768, -32768, 1, -32768, -32768, -32768);
    add_row(0, 0, 0, 0, -32768, 32767, 1, 1, -32768, 32767, 1);
    add_row(-ONE_Q, 0, 0, 0, 12345, -54, -1, 1, 12345, -54, -1);
    add_row(-32768, 0, 0, 0, 32767, -32768, 0, 1, 32767, -32768, 0);
    // half turns about each axis
    add_row(0, 0, 0, ONE_Q, -32768, 32767, -32768, 1, 32768, -32767, -32768);
    add_row(0, ONE_Q, 0, 0, 5, -32768, 32767, 1, 5, 32768, -32767);
    add_row(0, 0, ONE_Q, 0, -32768, 7, 32767, 1, 32768, 7, -32767);
    // non-unit quaternion driving both rails
    add_row(0, -32768, 0, 0, 100, -32768, 32767, 1, 100, 65535, -65536);
    add_row(ONE_Q, ONE_Q, ONE_Q, ONE_Q, 32767, -32768, 32767, 0);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    add_row(32767, 32767, 32767, 32767, 32767, -32768, 32767, 0);
    add_row(-ONE_Q, ONE_Q, -ONE_Q, ONE_Q, -1, 1, -1, 0);
    add_row(16'h5555, -21846, 16'h5555, -21846, 16'h5555, -21846, 16'h5555, 0);
    // exact halves: 0.5 scaling on x and y
    add_row(0, 0, 0, ONE_Q / 2, 1, -1, 5, 0);
    add_row(0, 0, 0, ONE_Q / 2, 3, -3, -7, 0);
    add_row(0, 0, 0, ONE_Q / 2, -32768, 32767, 0, 0);
    // quarter turn about z, third turn about the diagonal
    add_row(11585, 0, 0, 11585, 16384, 0, 0, 0);
    add_row(ONE_Q / 2, ONE_Q / 2, ONE_Q / 2, ONE_Q / 2, 1, 2, 3, 0);
    add_row(ONE_Q / 2, -ONE_Q / 2, ONE_Q / 2, -ONE_Q / 2, 32767, 0, -32768, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      pace_sender();
      drive_item(stim_rows[i].vec);
      world_expected.push_back(stim_rows[i].known ? stim_rows[i].want
                                                  : rotate_vector(stim_rows[i].vec));
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      pace_sender();
      v = random_vector();
      drive_item(v);
      world_expected.push_back(rotate_vector(v));
    end
    in_if.valid <= 1'b0;

    while (world_expected.size() != 0) @(posedge clk_i);
    repeat (4 * qvr_pkg::STAGES) @(posedge clk_i);

    $display("rotated %0d items (%0d from the table), %0d results compared",
             items_sent, stim_rows.size(), results_checked);
    $display("quaternions: unit, in-range and raw patterns; gaps and stalls throughout");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver stalls follow a 16-bit pattern that is reselected at random.
  initial begin : receiver
    logic [15:0] pat;
    int          phase;
    out_if.ready <= 1'b0;
    pat   = '1;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (phase % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '1;
          1: pat = 16'($urandom);
          2: pat = 16'($urandom & $urandom | 16'h0001);
          default: pat = 16'($urandom | $urandom);
        endcase
      end
      out_if.ready <= pat[phase[3:0]];
      phase++;
    end
  end

  always @(posedge clk_i) begin : result_check
    world_item_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (world_expected.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = world_expected.pop_front();
        if (out_if.world_acc_x !== want.world_acc_x)
          report_mismatch($sformatf("world_acc_x got %0d want %0d",
                                    out_if.world_acc_x, want.world_acc_x));
        if (out_if.world_acc_y !== want.world_acc_y)
          report_mismatch($sformatf("world_acc_y got %0d want %0d",
                                    out_if.world_acc_y, want.world_acc_y));
        if (out_if.world_acc_z !== want.world_acc_z)
          report_mismatch($sformatf("world_acc_z got %0d want %0d",
                                    out_if.world_acc_z, want.world_acc_z));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
